// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another on the same clock edge
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Check that a condition never holds
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: hw/rtl/sflr_pkg.sv
// Types, constants and helpers of the supervisory frame link receiver
`timescale 1ns / 1ps
`default_nettype none
package sflr_pkg;

	localparam logic [7:0] FLAG       = 8'h7E;
	localparam int         FRAME_LEN  = 5;
	localparam int         BEAT_W     = $clog2(FRAME_LEN);
	localparam int         FIFO_DEPTH = 4;
	localparam int         PTR_W      = $clog2(FIFO_DEPTH);
	localparam int         ADDR_W     = 5;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		M_START = 3'd0,
		M_FLAG  = 3'd1,
		M_ADDR  = 3'd2,
		M_CTRL  = 3'd3,
		M_BCC   = 3'd4
	} match_t;

	typedef enum logic [1:0] {
		JOB_FRAME = 2'd0,
		JOB_OK    = 2'd1,
		JOB_FAIL  = 2'd2
	} job_t;

	typedef enum logic [2:0] {
		REG_EXP_ADDR  = 3'd0,
		REG_EXP_CTRL  = 3'd1,
		REG_SEND_ADDR = 3'd2,
		REG_SEND_CTRL = 3'd3,
		REG_TIMEOUT   = 3'd4,
		REG_MAX_RETRY = 3'd5,
		REG_RETX_MODE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  expected_address;
		logic [7:0]  expected_control;
		logic [7:0]  send_address;
		logic [7:0]  send_control;
		logic [15:0] timeout_ticks;
		logic [3:0]  max_retries;
		logic        retransmit_mode;
	} cfg_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       frame_ok;
		logic       failed;
		logic       last;
	} res_t;

	function automatic logic [7:0] frame_byte(input logic [BEAT_W-1:0] beat,
		input logic [7:0] sa, input logic [7:0] sc);
		logic [7:0] b;
		case (beat)
			BEAT_W'(1): b = sa;
			BEAT_W'(2): b = sc;
			BEAT_W'(3): b = sa ^ sc;
			default:    b = FLAG;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sflr_if.sv
// Handshake channel interfaces for command items and result items
`timescale 1ns / 1ps
`default_nettype none
interface sflr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface sflr_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       frame_ok;
	logic       failed;
	logic       last;

	modport source (output valid, output tx_valid, output tx_byte, output frame_ok,
		output failed, output last, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input frame_ok,
		input failed, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sflr_regs.sv
// APB configuration registers
`timescale 1ns / 1ps
`default_nettype none
module sflr_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sflr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output sflr_pkg::cfg_t                  cfg
);
	import sflr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_address <= 8'd3;
			cfg_q.expected_control <= 8'd7;
			cfg_q.send_address     <= 8'd3;
			cfg_q.send_control     <= 8'd3;
			cfg_q.timeout_ticks    <= 16'd3;
			cfg_q.max_retries      <= 4'd3;
			cfg_q.retransmit_mode  <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_EXP_ADDR:  cfg_q.expected_address <= pwdata[7:0];
				REG_EXP_CTRL:  cfg_q.expected_control <= pwdata[7:0];
				REG_SEND_ADDR: cfg_q.send_address     <= pwdata[7:0];
				REG_SEND_CTRL: cfg_q.send_control     <= pwdata[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks    <= pwdata[15:0];
				REG_MAX_RETRY: cfg_q.max_retries      <= pwdata[3:0];
				REG_RETX_MODE: cfg_q.retransmit_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_EXP_ADDR:  prdata = {24'd0, cfg_q.expected_address};
			REG_EXP_CTRL:  prdata = {24'd0, cfg_q.expected_control};
			REG_SEND_ADDR: prdata = {24'd0, cfg_q.send_address};
			REG_SEND_CTRL: prdata = {24'd0, cfg_q.send_control};
			REG_TIMEOUT:   prdata = {16'd0, cfg_q.timeout_ticks};
			REG_MAX_RETRY: prdata = {28'd0, cfg_q.max_retries};
			REG_RETX_MODE: prdata = {31'd0, cfg_q.retransmit_mode};
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/sflr_front.sv
// Front end: accept items, run the frame matcher and timer, queue result jobs
`timescale 1ns / 1ps
`default_nettype none
module sflr_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sflr_in_if.sink       items,
	input  sflr_pkg::cfg_t cfg,
	input  wire logic     fifo_full,
	output logic          push,
	output sflr_pkg::job_t push_job
);
	import sflr_pkg::*;

	match_t      match_q, match_d, match_nx;
	logic        active_q, active_d;
	logic [15:0] tick_q, tick_d, tick_inc, limit;
	logic [3:0]  retry_q, retry_d;
	logic        accept;
	logic [7:0]  b, bcc;

	assign items.ready = !fifo_full;
	assign accept      = items.valid && items.ready;
	assign b           = items.rx_byte;
	assign bcc         = cfg.expected_address ^ cfg.expected_control;
	assign tick_inc    = tick_q + 16'd1;
	assign limit       = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;

	always_comb begin
		unique case (match_q)
			M_START: match_nx = (b == FLAG) ? M_FLAG : M_START;
			M_FLAG: begin
				if (b == FLAG)                       match_nx = M_FLAG;
				else if (b == cfg.expected_address)  match_nx = M_ADDR;
				else                                 match_nx = M_START;
			end
			M_ADDR: begin
				if (b == cfg.expected_control) match_nx = M_CTRL;
				else if (b == FLAG)            match_nx = M_FLAG;
				else                           match_nx = M_START;
			end
			M_CTRL: begin
				if (b == bcc)       match_nx = M_BCC;
				else if (b == FLAG) match_nx = M_FLAG;
				else                match_nx = M_START;
			end
			default: match_nx = M_START;
		endcase
	end

	always_comb begin
		match_d  = match_q;
		active_d = active_q;
		tick_d   = tick_q;
		retry_d  = retry_q;
		push     = 1'b0;
		push_job = JOB_FRAME;
		if (accept) begin
			case (items.command)
				CMD_START: begin
					match_d  = M_START;
					tick_d   = 16'd0;
					retry_d  = 4'd0;
					active_d = 1'b1;
					push     = cfg.retransmit_mode;
				end
				CMD_BYTE: begin
					if (active_q) begin
						if (match_q == M_BCC && b == FLAG) begin
							match_d  = M_START;
							active_d = 1'b0;
							tick_d   = 16'd0;
							retry_d  = 4'd0;
							push     = 1'b1;
							push_job = JOB_OK;
						end else begin
							match_d = match_nx;
						end
					end
				end
				CMD_TICK: begin
					if (active_q && cfg.retransmit_mode) begin
						if (tick_inc < limit) begin
							tick_d = tick_inc;
						end else begin
							tick_d  = 16'd0;
							match_d = M_START;
							push    = 1'b1;
							if (retry_q >= cfg.max_retries) begin
								active_d = 1'b0;
								push_job = JOB_FAIL;
							end else begin
								retry_d = retry_q + 4'd1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q  <= M_START;
			active_q <= 1'b0;
			tick_q   <= 16'd0;
			retry_q  <= 4'd0;
		end else begin
			match_q  <= match_d;
			active_q <= active_d;
			tick_q   <= tick_d;
			retry_q  <= retry_d;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sflr_fifo.sv
// Short job queue between front end and result emitter
`timescale 1ns / 1ps
`default_nettype none
module sflr_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  sflr_pkg::job_t push_job,
	input  wire logic      pop,
	output sflr_pkg::job_t pop_job,
	output logic           empty,
	output logic           full
);
	import sflr_pkg::*;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sflr_back.sv
// Back end: expand queued jobs into result items behind an output register
`timescale 1ns / 1ps
`default_nettype none
module sflr_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  sflr_pkg::cfg_t cfg,
	input  wire logic      fifo_empty,
	input  sflr_pkg::job_t pop_job,
	output logic           pop,
	sflr_out_if.source     results
);
	import sflr_pkg::*;

	logic              out_valid_q;
	res_t              res_q, res_d;
	logic              busy_q;
	logic [BEAT_W-1:0] beat_q;
	logic              advance;

	assign advance = !out_valid_q || results.ready;
	assign pop     = advance && !busy_q && !fifo_empty;

	always_comb begin
		res_d = '0;
		if (busy_q) begin
			res_d.tx_valid = 1'b1;
			res_d.tx_byte  = frame_byte(beat_q, cfg.send_address, cfg.send_control);
			res_d.last     = (beat_q == BEAT_W'(FRAME_LEN - 1));
		end else begin
			unique case (pop_job)
				JOB_FRAME: begin
					res_d.tx_valid = 1'b1;
					res_d.tx_byte  = FLAG;
				end
				JOB_OK: begin
					res_d.frame_ok = 1'b1;
					res_d.last     = 1'b1;
				end
				default: begin
					res_d.failed = 1'b1;
					res_d.last   = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (busy_q || !fifo_empty)) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			beat_q      <= '0;
		end else if (advance) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (beat_q == BEAT_W'(FRAME_LEN - 1)) begin
					busy_q <= 1'b0;
				end
				beat_q <= beat_q + BEAT_W'(1);
			end else if (!fifo_empty) begin
				out_valid_q <= 1'b1;
				if (pop_job == JOB_FRAME) begin
					busy_q <= 1'b1;
					beat_q <= BEAT_W'(1);
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid    = out_valid_q;
	assign results.tx_valid = res_q.tx_valid;
	assign results.tx_byte  = res_q.tx_byte;
	assign results.frame_ok = res_q.frame_ok;
	assign results.failed   = res_q.failed;
	assign results.last     = res_q.last;
endmodule
`default_nettype wire

// File: hw/rtl/supervisory_frame_link_receiver.sv
// The first result of an item passes the job queue and then the output register,
// and a stalled output can hold it. Throughput: one item per cycle while the
// four-entry job queue is not full; a resent frame gives five result items, and
// ready drops once the queue fills. Items that cause no result never enter the queue.
// Reset: arst_n clears matcher, timer, retry count, queue and output; registers
// return to their reset values at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module supervisory_frame_link_receiver (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sflr_in_if.sink                          items,
	sflr_out_if.source                       results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sflr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import sflr_pkg::*;

	cfg_t cfg;
	job_t push_job, pop_job;
	logic push;
	logic pop;
	logic fifo_empty;
	logic fifo_full;

	sflr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sflr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.fifo_full (fifo_full),
		.push      (push),
		.push_job  (push_job)
	);

	sflr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	sflr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fifo_empty (fifo_empty),
		.pop_job    (pop_job),
		.pop        (pop),
		.results    (results)
	);

	`ASSERT_NEVER(a_push_full, push && fifo_full)
	`ASSERT_NEVER(a_pop_empty, pop && fifo_empty)
	`ASSERT_IMP(a_status_last, results.valid && !results.tx_valid, results.last)
	`ASSERT_NEVER(a_ok_and_fail, results.valid && results.frame_ok && results.failed)
endmodule
`default_nettype wire
